@@ src/sms_pkg.sv @@
// Shared types and constants of the sector-minimum wall-follow steering block.
// No dependencies; every other file of the block except sms_if imports this package.
package sms_pkg;

    localparam int NSECT            = 12;
    localparam int SEC_W            = 4;
    localparam int SAMPLES_PER_SCAN = 360;
    localparam int LAST_ANGLE       = SAMPLES_PER_SCAN - 1;
    localparam int SECTOR_SPAN      = 30;
    // Reciprocal of the sector span, scaled by 2^SECTOR_SHIFT; exact for angles below 360.
    localparam int SECTOR_RECIP     = 1093;
    localparam int SECTOR_SHIFT     = 15;
    localparam int QUEUE_DEPTH      = 4;

    // Named sectors, counted counterclockwise from the front.
    localparam int S_FRONT       = 0;
    localparam int S_FRONT_LEFT  = 1;
    localparam int S_LEFT_FRONT  = 2;
    localparam int S_LEFT        = 3;
    localparam int S_LEFT_BACK   = 4;
    localparam int S_BACK_LEFT   = 5;
    localparam int S_BACK        = 6;
    localparam int S_BACK_RIGHT  = 7;
    localparam int S_FRONT_RIGHT = 11;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_LOWER_RADIUS = 3'd0;
    localparam logic [2:0] REG_UPPER_RADIUS = 3'd1;
    localparam logic [2:0] REG_FRONT_CLEAR  = 3'd2;
    localparam logic [2:0] REG_CORNER_FRONT = 3'd3;
    localparam logic [2:0] REG_BACK_CLEAR   = 3'd4;
    localparam logic [2:0] REG_BACK_LEFT    = 3'd5;
    localparam logic [2:0] REG_CORNER_WALL  = 3'd6;
    localparam logic [2:0] REG_TILT_MARGIN  = 3'd7;

    // Speed commands.
    localparam logic [7:0]        LIN_STOP   = 8'd0;
    localparam logic [7:0]        LIN_SLOW   = 8'd30;
    localparam logic [7:0]        LIN_TURN   = 8'd70;
    localparam logic [7:0]        LIN_CRUISE = 8'd250;
    localparam logic signed [9:0] ANG_NONE       = 10'sd0;
    localparam logic signed [9:0] ANG_LEFT       = 10'sd100;
    localparam logic signed [9:0] ANG_RIGHT      = -10'sd100;
    localparam logic signed [9:0] ANG_HARD_RIGHT = -10'sd200;
    localparam logic signed [9:0] ANG_CORNER     = 10'sd300;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_HUG    = 2'd1,
        MODE_OUTER  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_STOP   = 2'd2
    } t_kind;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        t_kind              kind;
        logic               fold;
        logic               commit;
        logic [SEC_W-1:0]   sec;
        logic [15:0]        range_mm;
    } t_item;

    typedef struct packed {
        logic [15:0] lower_radius_mm;
        logic [15:0] upper_radius_mm;
        logic [15:0] front_clear_mm;
        logic [15:0] corner_front_clear_mm;
        logic [15:0] back_clear_mm;
        logic [15:0] back_left_clear_mm;
        logic [15:0] corner_wall_mm;
        logic [9:0]  tilt_margin_mm;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        lower_radius_mm:       16'd200,
        upper_radius_mm:       16'd350,
        front_clear_mm:        16'd450,
        corner_front_clear_mm: 16'd300,
        back_clear_mm:         16'd200,
        back_left_clear_mm:    16'd230,
        corner_wall_mm:        16'd500,
        tilt_margin_mm:        10'd20
    };

endpackage

@@ src/sms_if.sv @@
// Valid/ready channel interfaces for the request and result streams.
// Standalone; used by the front end, the back end and the top level.
interface sms_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [8:0]  angle_deg;
    logic [15:0] range_mm;
    logic        at_home;

    modport source (output valid, command, angle_deg, range_mm, at_home, input ready);
    modport sink   (input valid, command, angle_deg, range_mm, at_home, output ready);
endinterface

interface sms_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        linear_mm_s;
    logic signed [9:0] angular_mrad_s;

    modport source (output valid, linear_mm_s, angular_mrad_s, input ready);
    modport sink   (input valid, linear_mm_s, angular_mrad_s, output ready);
endinterface

@@ src/sms_cfg.sv @@
// APB-style register file holding the steering thresholds.
// Depends on sms_pkg for the register indexes and the threshold struct.
module sms_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output sms_pkg::t_cfg o_cfg
);
    import sms_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOWER_RADIUS: r_cfg.lower_radius_mm       <= pwdata[15:0];
                REG_UPPER_RADIUS: r_cfg.upper_radius_mm       <= pwdata[15:0];
                REG_FRONT_CLEAR:  r_cfg.front_clear_mm        <= pwdata[15:0];
                REG_CORNER_FRONT: r_cfg.corner_front_clear_mm <= pwdata[15:0];
                REG_BACK_CLEAR:   r_cfg.back_clear_mm         <= pwdata[15:0];
                REG_BACK_LEFT:    r_cfg.back_left_clear_mm    <= pwdata[15:0];
                REG_CORNER_WALL:  r_cfg.corner_wall_mm        <= pwdata[15:0];
                REG_TILT_MARGIN:  r_cfg.tilt_margin_mm        <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LOWER_RADIUS: prdata = {16'd0, r_cfg.lower_radius_mm};
            REG_UPPER_RADIUS: prdata = {16'd0, r_cfg.upper_radius_mm};
            REG_FRONT_CLEAR:  prdata = {16'd0, r_cfg.front_clear_mm};
            REG_CORNER_FRONT: prdata = {16'd0, r_cfg.corner_front_clear_mm};
            REG_BACK_CLEAR:   prdata = {16'd0, r_cfg.back_clear_mm};
            REG_BACK_LEFT:    prdata = {16'd0, r_cfg.back_left_clear_mm};
            REG_CORNER_WALL:  prdata = {16'd0, r_cfg.corner_wall_mm};
            REG_TILT_MARGIN:  prdata = {22'd0, r_cfg.tilt_margin_mm};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

@@ src/sms_front.sv @@
// Front end: accepts requests and classifies them (sector, fold, scan commit, tick kind).
// Depends on sms_pkg and the sms_in_if interface.
module sms_front #(
    parameter int BEAM_HALF_WIDTH = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sms_in_if.sink         i_in,
    output logic           o_push_valid,
    output sms_pkg::t_item o_push_item,
    input  logic           i_push_ready
);
    import sms_pkg::*;

    logic              r_vld;
    t_item             r_item;
    t_item             n_item;
    logic [9:0]        ang_sum;
    logic [8:0]        off;
    logic [19:0]       prod;
    logic [SEC_W-1:0]  sec;
    logic [8:0]        pos;
    logic              in_scan;
    logic              take_in;

    assign i_in.ready   = !r_vld || i_push_ready;
    assign take_in      = i_in.valid && i_in.ready;
    assign o_push_valid = r_vld;
    assign o_push_item  = r_item;

    // Shift the beam so each sector starts at offset zero, then split by the sector span.
    always_comb begin
        ang_sum = {1'b0, i_in.angle_deg} + 10'(BEAM_HALF_WIDTH);
        if (ang_sum >= 10'(SAMPLES_PER_SCAN)) begin
            off = 9'(ang_sum - 10'(SAMPLES_PER_SCAN));
        end else begin
            off = ang_sum[8:0];
        end
        prod    = 20'(off) * 20'(SECTOR_RECIP);
        sec     = prod[SECTOR_SHIFT +: SEC_W];
        pos     = off - 9'(sec) * 9'(SECTOR_SPAN);
        in_scan = i_in.angle_deg < 9'(SAMPLES_PER_SCAN);
    end

    always_comb begin
        n_item          = '0;
        n_item.sec      = sec;
        n_item.range_mm = i_in.range_mm;
        if (i_in.command) begin
            n_item.kind = i_in.at_home ? KIND_STOP : KIND_TICK;
        end else begin
            n_item.kind   = KIND_SAMPLE;
            n_item.fold   = in_scan && (sec < SEC_W'(NSECT)) &&
                            (pos < 9'(2 * BEAM_HALF_WIDTH)) && (i_in.range_mm != 16'd0);
            n_item.commit = i_in.angle_deg == 9'(LAST_ANGLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take_in) begin
            r_vld <= 1'b1;
        end else if (i_push_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_item <= n_item;
        end
    end

endmodule

@@ src/sms_fifo.sv @@
// Short request queue between the front end and the back end.
// Depends on sms_pkg for the request struct and the queue depth.
module sms_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  sms_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output sms_pkg::t_item o_pop_item,
    input  logic           i_pop
);
    import sms_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

endmodule

@@ src/sms_back.sv @@
// Back end: sector minima, committed sector distances, follow mode and the speed result.
// Depends on sms_pkg and the sms_out_if interface.
module sms_back #(
    parameter int RANGE_LIMIT_MM = 3500
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sms_pkg::t_cfg  i_cfg,
    input  logic           i_head_valid,
    input  sms_pkg::t_item i_head,
    output logic           o_pop,
    sms_out_if.source      o_out
);
    import sms_pkg::*;

    logic [15:0]        r_work [NSECT];
    logic [15:0]        r_dist [NSECT];
    t_mode              r_mode;
    t_mode              n_mode;
    logic               r_out_vld;
    logic [7:0]         r_lin;
    logic signed [9:0]  r_ang;

    logic               out_free;
    logic               is_sample;
    logic               do_sample;
    logic               do_tick;
    logic               take_min;
    logic [15:0]        cur_min;
    logic               emit;
    logic [7:0]         emit_lin;
    logic signed [9:0]  emit_ang;

    logic [15:0]        lf;
    logic [15:0]        lm;
    logic [15:0]        lb;
    logic               front_near;
    logic               corner_near;
    logic               back_near;
    logic               lf_low;
    logic               l_low;
    logic               l_high;
    logic               lf_high;
    logic               lb_high;
    logic               lb_wall;
    logic               tilt_out;
    logic               tilt_in;

    assign out_free  = !r_out_vld || o_out.ready;
    assign is_sample = i_head.kind == KIND_SAMPLE;
    // Samples never produce a result, so they drain even while the output waits.
    assign o_pop     = i_head_valid && (is_sample || out_free);
    assign do_sample = o_pop && is_sample;
    assign do_tick   = o_pop && (i_head.kind == KIND_TICK);
    assign cur_min   = r_work[i_head.sec];
    assign take_min  = i_head.fold && (i_head.range_mm < cur_min);

    assign o_out.valid          = r_out_vld;
    assign o_out.linear_mm_s    = r_lin;
    assign o_out.angular_mrad_s = r_ang;

    // Threshold comparisons on the committed scan.
    always_comb begin
        lf          = r_dist[S_LEFT_FRONT];
        lm          = r_dist[S_LEFT];
        lb          = r_dist[S_LEFT_BACK];
        front_near  = (r_dist[S_FRONT] < i_cfg.front_clear_mm) ||
                      (r_dist[S_FRONT_LEFT] < i_cfg.front_clear_mm) ||
                      (r_dist[S_FRONT_RIGHT] < i_cfg.front_clear_mm);
        corner_near = (r_dist[S_FRONT] < i_cfg.corner_front_clear_mm) ||
                      (r_dist[S_FRONT_LEFT] < i_cfg.corner_front_clear_mm) ||
                      (r_dist[S_FRONT_RIGHT] < i_cfg.corner_front_clear_mm);
        back_near   = (r_dist[S_BACK] < i_cfg.back_clear_mm) ||
                      (r_dist[S_BACK_LEFT] < i_cfg.back_left_clear_mm) ||
                      (r_dist[S_BACK_RIGHT] < i_cfg.back_clear_mm);
        lf_low      = lf < i_cfg.lower_radius_mm;
        l_low       = lm < i_cfg.lower_radius_mm;
        l_high      = lm > i_cfg.upper_radius_mm;
        lf_high     = lf > i_cfg.upper_radius_mm;
        lb_high     = lb > i_cfg.upper_radius_mm;
        lb_wall     = lb < i_cfg.corner_wall_mm;
        tilt_out    = {1'b0, lb} > ({1'b0, lf} + 17'(i_cfg.tilt_margin_mm));
        tilt_in     = {1'b0, lf} > ({1'b0, lb} + 17'(i_cfg.tilt_margin_mm));
    end

    // Next follow mode.
    always_comb begin
        n_mode = r_mode;
        if (do_tick) begin
            case (r_mode)
                MODE_HUG: begin
                    if (front_near || (!lf_low && !l_low &&
                                       (l_high || (!tilt_out && !tilt_in)))) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_OUTER: begin
                    if (corner_near || !(l_high || lf_high)) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                default: begin
                    if (back_near || front_near) begin
                        n_mode = MODE_NORMAL;
                    end else if (l_low) begin
                        n_mode = MODE_HUG;
                    end else if (l_high && lb_wall) begin
                        n_mode = MODE_OUTER;
                    end else begin
                        n_mode = MODE_NORMAL;
                    end
                end
            endcase
        end
    end

    // Speed result of the request at the head of the queue.
    always_comb begin
        emit     = 1'b0;
        emit_lin = LIN_STOP;
        emit_ang = ANG_NONE;
        if (o_pop && (i_head.kind == KIND_STOP)) begin
            emit = 1'b1;
        end else if (do_tick) begin
            case (r_mode)
                MODE_HUG: begin
                    if (front_near) begin
                        emit = 1'b0;
                    end else if (lf_low) begin
                        emit     = 1'b1;
                        emit_ang = ANG_RIGHT;
                    end else if (l_low) begin
                        emit     = 1'b1;
                        emit_lin = LIN_TURN;
                        emit_ang = ANG_RIGHT;
                    end else if (l_high) begin
                        emit = 1'b0;
                    end else if (tilt_out) begin
                        emit     = 1'b1;
                        emit_lin = LIN_TURN;
                        emit_ang = ANG_RIGHT;
                    end else if (tilt_in) begin
                        emit     = 1'b1;
                        emit_lin = LIN_TURN;
                        emit_ang = ANG_LEFT;
                    end
                end
                MODE_OUTER: begin
                    if (!corner_near && (l_high || lf_high)) begin
                        emit     = 1'b1;
                        emit_lin = LIN_TURN;
                        emit_ang = ANG_CORNER;
                    end
                end
                default: begin
                    if (back_near) begin
                        emit     = 1'b1;
                        emit_lin = LIN_SLOW;
                    end else if (front_near) begin
                        emit     = 1'b1;
                        emit_ang = ANG_HARD_RIGHT;
                    end else if (l_low) begin
                        emit     = 1'b1;
                        emit_lin = LIN_SLOW;
                        emit_ang = ANG_RIGHT;
                    end else if (l_high && lb_wall) begin
                        emit = 1'b0;
                    end else if (lf_high || l_high || lb_high) begin
                        emit     = 1'b1;
                        emit_lin = LIN_TURN;
                        emit_ang = ANG_LEFT;
                    end else begin
                        emit     = 1'b1;
                        emit_lin = LIN_CRUISE;
                    end
                end
            endcase
        end
    end

    // Sector minima and the committed scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSECT; i++) begin
                r_work[i] <= 16'(RANGE_LIMIT_MM);
                r_dist[i] <= 16'd0;
            end
        end else if (do_sample) begin
            for (int i = 0; i < NSECT; i++) begin
                if (i_head.commit) begin
                    r_dist[i] <= (take_min && (i_head.sec == SEC_W'(i))) ?
                                 i_head.range_mm : r_work[i];
                    r_work[i] <= 16'(RANGE_LIMIT_MM);
                end else if (take_min && (i_head.sec == SEC_W'(i))) begin
                    r_work[i] <= i_head.range_mm;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_out_vld <= 1'b0;
        end else begin
            r_mode <= n_mode;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_lin <= emit_lin;
            r_ang <= emit_ang;
        end
    end

    // A stop request always loads a zero speed result.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.kind == KIND_STOP) |=>
            (r_out_vld && r_lin == LIN_STOP && r_ang == ANG_NONE))
        else $error("stop request did not load a zero result");

    // The mode moves only on a tick.
    a_mode_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !do_tick |=> $stable(r_mode))
        else $error("follow mode changed without a tick");

    // A scan commit re-arms the working minima.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_sample && i_head.commit) |=>
            (r_work[S_LEFT] == 16'(RANGE_LIMIT_MM) && r_work[S_BACK] == 16'(RANGE_LIMIT_MM)))
        else $error("working minima not re-armed after scan commit");

endmodule

@@ src/sector_minimum_wall_follow_steer.sv @@
// Top level of the sector-minimum wall-follow steering block.
// Depends on sms_pkg, sms_if, sms_cfg, sms_front, sms_fifo and sms_back.
//
//   Channel   Direction  Handshake            Carries
//   i_in      in         valid/ready          command, angle_deg, range_mm, at_home
//   o_out     out        valid/ready          linear_mm_s, angular_mrad_s
//   APB       in/out     psel/penable/pready  eight threshold registers at 4*index
//
// One request is accepted per cycle while the input is not stalled. A request is
// captured in the front-end register when it is accepted, moves from there into
// the four-entry queue and is carried out by the back end while it sits at the
// head; a tick's result is loaded into the output register as the tick leaves
// the queue. Reset is synchronous and active low; there is no clearing pass.
// A stalled output holds only ticks and stops at the queue head: samples keep
// draining, and the input stalls only when the queue and front register are full.
//
// The front end splits each range sample into its 30-degree sector with a
// multiply by the reciprocal of the sector span, marks whether the beam lands
// inside the sector window and whether it closes the scan, and tags ticks,
// with ticks near the start becoming stop requests. The back end keeps the
// twelve working minima, the committed sector distances and the follow mode,
// and turns each tick into at most one speed result held in an output register.
module sector_minimum_wall_follow_steer #(
    parameter int BEAM_HALF_WIDTH = 5,
    parameter int RANGE_LIMIT_MM  = 3500
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sms_in_if.sink      i_in,
    sms_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sms_pkg::*;

    t_cfg  cfg;
    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  head_valid;
    t_item head_item;
    logic  pop;

    // Threshold registers; user must write only while block is idle (unchecked).
    sms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front end: classifies each request as it arrives.
    sms_front #(
        .BEAM_HALF_WIDTH (BEAM_HALF_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    // The queue lets the front keep taking samples while a result waits.
    sms_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (head_valid),
        .o_pop_item   (head_item),
        .i_pop        (pop)
    );

    // Back end: sector state, follow mode and the result register.
    sms_back #(
        .RANGE_LIMIT_MM (RANGE_LIMIT_MM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sector-minimum wall-follow steering block.
// Depends on sms_pkg and on the sms_in_if / sms_out_if channel interfaces of the RTL.
// Drives scans and control ticks, predicts every speed command and compares it.
module tb_top;
    import sms_pkg::*;

    // The block is built with its default beam window and range limit; the
    // predictor uses the same values.
    localparam int BEAM_HALF_WIDTH = 5;
    localparam int RANGE_LIMIT_MM  = 3500;

    localparam int CLK_PERIOD     = 12;
    localparam int CLK_HALF       = CLK_PERIOD / 2;
    localparam int RESET_CYCLES   = 5;
    // A request may sit in the front register and the four-entry queue before
    // the back end executes it, so this many quiet cycles flush the pipeline.
    localparam int DRAIN_CYCLES   = 12;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int STALL_CYCLES   = 100;

    // Values of the command field of a request.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // One speed command as it leaves the block.
    typedef struct packed {
        logic [7:0]        lin;
        logic signed [9:0] ang;
    } t_speed_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sms_in_if  in_if ();
    sms_out_if out_if ();

    sector_minimum_wall_follow_steer #(
        .BEAM_HALF_WIDTH (BEAM_HALF_WIDTH),
        .RANGE_LIMIT_MM  (RANGE_LIMIT_MM)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted state of the block: its own copy of the thresholds, the
    // per-scan working minima, the committed sector distances and the mode.
    // ------------------------------------------------------------------
    t_cfg        steer_cfg;
    logic [15:0] working_min [NSECT];
    logic [15:0] sector_dist [NSECT];
    t_mode       follow_mode;

    // Speed commands predicted but not yet seen on the output, oldest first.
    t_speed_cmd  pending_speeds [$];

    int  mismatch_count = 0;
    int  requests_sent  = 0;

    // Shared pacing controls. gaps_enabled switches the random idling of both
    // sides; sink_hold_cycles asks the result side for one long hold-off.
    bit  gaps_enabled     = 1'b1;
    int  sink_hold_cycles = 0;

    // Sender bookkeeping: offer_held is set when valid was left high at the
    // last acceptance because the next request follows with no gap.
    bit  offer_held = 1'b0;
    int  next_gap   = 1;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic clear_steering_state();
        int s;
        steer_cfg   = CFG_RESET;
        follow_mode = MODE_NORMAL;
        for (s = 0; s < NSECT; s++) begin
            working_min[s] = 16'(RANGE_LIMIT_MM);
            sector_dist[s] = '0;
        end
    endtask

    // True when any of the three forward-facing sectors is closer than the
    // given threshold.
    function automatic bit front_closer_than(input int unsigned thr);
        return sector_dist[S_FRONT] < thr || sector_dist[S_FRONT_LEFT] < thr ||
               sector_dist[S_FRONT_RIGHT] < thr;
    endfunction

    // Folds one range sample into its sector. Only beams inside the window of
    // a sector count, a zero reading means no return, and angle 359 closes the
    // scan whether or not its own reading was folded.
    task automatic fold_range_sample(input logic [8:0] angle, input logic [15:0] dist_mm);
        int unsigned off;
        int unsigned sec;
        int unsigned pos;
        int          s;
        if (angle >= SAMPLES_PER_SCAN)
            return;
        off = (angle + BEAM_HALF_WIDTH) % SAMPLES_PER_SCAN;
        sec = off / SECTOR_SPAN;
        pos = off % SECTOR_SPAN;
        if (sec < NSECT && pos < 2 * BEAM_HALF_WIDTH && dist_mm != 0 &&
            dist_mm < working_min[sec])
            working_min[sec] = dist_mm;
        if (angle == LAST_ANGLE) begin
            for (s = 0; s < NSECT; s++) begin
                sector_dist[s] = working_min[s];
                working_min[s] = 16'(RANGE_LIMIT_MM);
            end
        end
    endtask

    // Threshold rules of one control tick. Returns 1 with the speed command
    // when the tick produces one; a tick that only changes the mode returns 0.
    function automatic bit steering_decision(output t_speed_cmd cmd);
        int unsigned lf;
        int unsigned lm;
        int unsigned lb;
        lf  = sector_dist[S_LEFT_FRONT];
        lm  = sector_dist[S_LEFT];
        lb  = sector_dist[S_LEFT_BACK];
        cmd = '{LIN_STOP, ANG_NONE};

        case (follow_mode)
            MODE_HUG: begin
                if (front_closer_than(steer_cfg.front_clear_mm)) begin
                    follow_mode = MODE_NORMAL;
                    return 1'b0;
                end
                if (lf < steer_cfg.lower_radius_mm) begin
                    cmd = '{LIN_STOP, ANG_RIGHT};
                    return 1'b1;
                end
                if (lm < steer_cfg.lower_radius_mm) begin
                    cmd = '{LIN_TURN, ANG_RIGHT};
                    return 1'b1;
                end
                if (lm > steer_cfg.upper_radius_mm) begin
                    follow_mode = MODE_NORMAL;
                    return 1'b0;
                end
                if (lb > lf + steer_cfg.tilt_margin_mm) begin
                    cmd = '{LIN_TURN, ANG_RIGHT};
                    return 1'b1;
                end
                if (lf > lb + steer_cfg.tilt_margin_mm) begin
                    cmd = '{LIN_TURN, ANG_LEFT};
                    return 1'b1;
                end
                follow_mode = MODE_NORMAL;
                return 1'b0;
            end
            MODE_OUTER: begin
                if (front_closer_than(steer_cfg.corner_front_clear_mm)) begin
                    follow_mode = MODE_NORMAL;
                    return 1'b0;
                end
                if (lm > steer_cfg.upper_radius_mm || lf > steer_cfg.upper_radius_mm) begin
                    cmd = '{LIN_TURN, ANG_CORNER};
                    return 1'b1;
                end
                follow_mode = MODE_NORMAL;
                return 1'b0;
            end
            default: ;
        endcase

        // Normal mode, which is also where an unknown mode code ends up.
        follow_mode = MODE_NORMAL;
        if (sector_dist[S_BACK] < steer_cfg.back_clear_mm ||
            sector_dist[S_BACK_LEFT] < steer_cfg.back_left_clear_mm ||
            sector_dist[S_BACK_RIGHT] < steer_cfg.back_clear_mm) begin
            cmd = '{LIN_SLOW, ANG_NONE};
            return 1'b1;
        end
        if (front_closer_than(steer_cfg.front_clear_mm)) begin
            cmd = '{LIN_STOP, ANG_HARD_RIGHT};
            return 1'b1;
        end
        if (lm < steer_cfg.lower_radius_mm) begin
            follow_mode = MODE_HUG;
            cmd = '{LIN_SLOW, ANG_RIGHT};
            return 1'b1;
        end
        if (lm > steer_cfg.upper_radius_mm && lb < steer_cfg.corner_wall_mm) begin
            follow_mode = MODE_OUTER;
            return 1'b0;
        end
        if (lf > steer_cfg.upper_radius_mm || lm > steer_cfg.upper_radius_mm ||
            lb > steer_cfg.upper_radius_mm) begin
            cmd = '{LIN_TURN, ANG_LEFT};
            return 1'b1;
        end
        cmd = '{LIN_CRUISE, ANG_NONE};
        return 1'b1;
    endfunction

    // Updates the predicted state for one accepted request and queues the
    // speed command it must produce, if any. A tick near the start always
    // stops the robot and leaves the mode alone.
    task automatic predict_request(input logic cmd_bit, input logic [8:0] angle,
                                   input logic [15:0] dist_mm, input logic near_flag);
        t_speed_cmd cmd;
        if (cmd_bit == CMD_SAMPLE)
            fold_range_sample(angle, dist_mm);
        else if (near_flag)
            pending_speeds.push_back('{LIN_STOP, ANG_NONE});
        else if (steering_decision(cmd))
            pending_speeds.push_back(cmd);
    endtask

    // ------------------------------------------------------------------
    // Request side. Every call starts and ends on a rising edge. The gap
    // before the next request is drawn at acceptance, so valid is either
    // lowered right there or kept high for a back-to-back request, and never
    // lowered and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic cmd_bit, input logic [8:0] angle,
                                input logic [15:0] dist_mm, input logic near_flag);
        if (!offer_held)
            repeat (next_gap) @(posedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd_bit;
        in_if.angle_deg <= angle;
        in_if.range_mm  <= dist_mm;
        in_if.at_home   <= near_flag;
        do @(posedge i_clk); while (!in_if.ready);

        predict_request(cmd_bit, angle, dist_mm, near_flag);
        if (cmd_bit == CMD_TICK || angle < SAMPLES_PER_SCAN)
            requests_sent++;

        next_gap   = gaps_enabled ? $urandom_range(0, 3) : 0;
        offer_held = (next_gap == 0);
        if (!offer_held)
            in_if.valid <= 1'b0;
    endtask

    // A sample carries a random at_home bit; the block must ignore it.
    task automatic send_sample(input int angle, input int dist_mm);
        send_request(CMD_SAMPLE, 9'(angle), 16'(dist_mm), 1'($urandom_range(0, 1)));
    endtask

    // A tick carries random angle and range fields, which must be ignored.
    task automatic send_tick(input logic near_flag);
        send_request(CMD_TICK, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)),
                     near_flag);
    endtask

    // Takes valid down when the sender pauses for something other than the
    // next request, and makes the next request wait for a gap first.
    task automatic end_stream();
        if (offer_held)
            in_if.valid <= 1'b0;
        offer_held = 1'b0;
        if (next_gap == 0)
            next_gap = 1;
    endtask

    // Waits until every predicted speed command has come out, then lets the
    // pipeline flush requests that produce no result.
    task automatic wait_for_drain();
        end_stream();
        while (pending_speeds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup phase, access phase, then a quiet phase so
    // that back-to-back writes never drive psel twice in one step.
    // ------------------------------------------------------------------
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);

        case (idx)
            REG_LOWER_RADIUS: steer_cfg.lower_radius_mm       = value;
            REG_UPPER_RADIUS: steer_cfg.upper_radius_mm       = value;
            REG_FRONT_CLEAR:  steer_cfg.front_clear_mm        = value;
            REG_CORNER_FRONT: steer_cfg.corner_front_clear_mm = value;
            REG_BACK_CLEAR:   steer_cfg.back_clear_mm         = value;
            REG_BACK_LEFT:    steer_cfg.back_left_clear_mm    = value;
            REG_CORNER_WALL:  steer_cfg.corner_wall_mm        = value;
            REG_TILT_MARGIN:  steer_cfg.tilt_margin_mm        = value[9:0];
            default: ;
        endcase
    endtask

    // Writes all eight thresholds; only called once the block is idle.
    task automatic apply_settings(input t_cfg c);
        wait_for_drain();
        write_register(REG_LOWER_RADIUS, c.lower_radius_mm);
        write_register(REG_UPPER_RADIUS, c.upper_radius_mm);
        write_register(REG_FRONT_CLEAR,  c.front_clear_mm);
        write_register(REG_CORNER_FRONT, c.corner_front_clear_mm);
        write_register(REG_BACK_CLEAR,   c.back_clear_mm);
        write_register(REG_BACK_LEFT,    c.back_left_clear_mm);
        write_register(REG_CORNER_WALL,  c.corner_wall_mm);
        write_register(REG_TILT_MARGIN,  {6'd0, c.tilt_margin_mm});
    endtask

    // Thresholds spread around the usual working point, so that the left
    // readings of a scan fall on both sides of them and every mode is visited.
    function automatic t_cfg plausible_settings();
        t_cfg c;
        c.lower_radius_mm       = 16'($urandom_range(120, 300));
        c.upper_radius_mm       = 16'($urandom_range(250, 500));
        c.front_clear_mm        = 16'($urandom_range(200, 700));
        c.corner_front_clear_mm = 16'($urandom_range(150, 500));
        c.back_clear_mm         = 16'($urandom_range(100, 300));
        c.back_left_clear_mm    = 16'($urandom_range(100, 300));
        c.corner_wall_mm        = 16'($urandom_range(300, 800));
        c.tilt_margin_mm        = 10'($urandom_range(0, 120));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Scan generation.
    // ------------------------------------------------------------------

    // Reading for a sample that lands in the given sector. Left sectors sit
    // around the wall-following radii; front and back sectors are mostly
    // clear with an occasional obstacle. A few readings are zero or anything
    // the field can hold.
    function automatic logic [15:0] pick_range(input int s);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 16'd0;
        if (roll == 1)
            return 16'($urandom_range(0, 65535));
        case (s)
            S_LEFT_FRONT, S_LEFT, S_LEFT_BACK:
                return 16'($urandom_range(100, 700));
            S_FRONT, S_FRONT_LEFT, S_FRONT_RIGHT, S_BACK_LEFT, S_BACK, S_BACK_RIGHT:
                return (roll < 5) ? 16'($urandom_range(50, 500)) :
                                    16'($urandom_range(500, 3499));
            default:
                return 16'($urandom_range(50, 3499));
        endcase
    endfunction

    // Something outside the normal flow of a scan: a beam between sectors,
    // an angle past the end of a scan, any sample at all, or an early tick.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_sample((SECTOR_SPAN * $urandom_range(0, NSECT - 1) + BEAM_HALF_WIDTH +
                            $urandom_range(0, SECTOR_SPAN - 2 * BEAM_HALF_WIDTH - 1)) %
                           SAMPLES_PER_SCAN, $urandom_range(1, 65535));
            1: send_sample($urandom_range(SAMPLES_PER_SCAN, 511), $urandom_range(0, 65535));
            2: send_sample($urandom_range(0, LAST_ANGLE), $urandom_range(0, 65535));
            default: send_tick(1'($urandom_range(0, 1)));
        endcase
    endtask

    // One scan: up to two in-window beams per sector, usually closed by angle 359,
    // followed by a burst of ticks so that the mode can evolve over them.
    // A scan left open carries its minima into the next one.
    task automatic random_scan();
        int s;
        int k;
        int reps;
        for (s = 0; s < NSECT; s++) begin
            reps = $urandom_range(0, 2);
            for (k = 0; k < reps; k++)
                send_sample((SECTOR_SPAN * s + SAMPLES_PER_SCAN - BEAM_HALF_WIDTH +
                             $urandom_range(0, 2 * BEAM_HALF_WIDTH - 1)) % SAMPLES_PER_SCAN,
                            pick_range(s));
            if ($urandom_range(0, 15) == 0)
                send_noise();
        end
        if ($urandom_range(0, 9) != 0)
            send_sample(LAST_ANGLE, pick_range(S_FRONT));
        reps = $urandom_range(1, 5);
        for (k = 0; k < reps; k++)
            send_tick($urandom_range(0, 9) == 0);
    endtask

    task automatic run_scans(input int budget);
        int target;
        target = requests_sent + budget;
        while (requests_sent < target)
            random_scan();
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-picked requests with the reset thresholds: the tick at reset,
    // a stop near the start with extreme junk fields, ignored angles, beams
    // on the edges of a sector window and between windows, a zero reading,
    // a reading above the limit, and scans that walk the mode from normal
    // into wall hugging, out again and into the outer corner turn.
    task automatic test_directed();
        apply_settings(CFG_RESET);

        // Sector distances are all zero after reset, which reads as an
        // obstacle behind the robot.
        send_request(CMD_TICK, 9'd0, 16'd0, 1'b0);
        send_request(CMD_TICK, 9'd511, 16'd65535, 1'b1);
        send_sample(SAMPLES_PER_SCAN, 10);
        send_sample(511, 1);

        // Left wall close; front window edges, a beam between windows and a
        // zero reading leave the front sector to the closing reading at 359.
        send_sample(90, 150);
        send_sample(94, 65535);
        send_sample(5, 50);
        send_sample(355, 0);
        send_sample(LAST_ANGLE, 3000);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // Left wall within the band but tilted away at the back.
        send_sample(120, 400);
        send_sample(85, 250);
        send_sample(60, 250);
        send_sample(LAST_ANGLE, 3000);
        send_tick(1'b0);
        send_tick(1'b0);

        // Left opening with a wall behind it: leave hugging, enter the
        // corner turn, then turn around the corner.
        send_sample(90, 400);
        send_sample(124, 300);
        send_sample(LAST_ANGLE, 3000);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    task automatic test_default_scans();
        apply_settings(CFG_RESET);
        run_scans(250);
    endtask

    // All thresholds at zero, where nothing is ever too close, then all at
    // their largest value, where everything is, and then with the tilt margin at 1000.
    task automatic test_register_extremes();
        t_cfg c;
        c = '{default: '0};
        apply_settings(c);
        run_scans(70);
        c = '{default: '1};
        apply_settings(c);
        run_scans(70);
        c.tilt_margin_mm = 10'd1000;
        apply_settings(c);
        run_scans(20);
    endtask

    // Several plausible threshold sets, and one drawn from the whole range.
    task automatic test_random_settings();
        t_cfg c;
        int   n;
        for (n = 0; n < 4; n++) begin
            apply_settings(plausible_settings());
            run_scans(70);
        end
        c.lower_radius_mm       = 16'($urandom_range(0, 65535));
        c.upper_radius_mm       = 16'($urandom_range(0, 65535));
        c.front_clear_mm        = 16'($urandom_range(0, 65535));
        c.corner_front_clear_mm = 16'($urandom_range(0, 65535));
        c.back_clear_mm         = 16'($urandom_range(0, 65535));
        c.back_left_clear_mm    = 16'($urandom_range(0, 65535));
        c.corner_wall_mm        = 16'($urandom_range(0, 65535));
        c.tilt_margin_mm        = 10'($urandom_range(0, 1023));
        apply_settings(c);
        run_scans(40);
    endtask

    // Both sides at full rate: a request every cycle unless the input stalls, and the
    // result side always ready.
    task automatic test_back_to_back();
        apply_settings(plausible_settings());
        gaps_enabled = 1'b0;
        run_scans(100);
        gaps_enabled = 1'b1;
    endtask

    // The result side holds off for a long stretch while ticks keep coming,
    // so the queue fills with pending results and the input must stall.
    // Ticks are mostly near the start, because each of those is sure to produce a
    // result; a few scans in between keep the rest of the state moving.
    task automatic test_output_stall();
        int k;
        apply_settings(CFG_RESET);
        sink_hold_cycles = STALL_CYCLES;
        for (k = 0; k < 24; k++)
            send_tick($urandom_range(0, 3) != 0);
        run_scans(40);
    endtask

    // ------------------------------------------------------------------
    // Result side: before every result it may hold ready low while gaps are
    // enabled, or takes the long hold-off when one is asked for.
    // ------------------------------------------------------------------
    initial begin : speed_sink
        int wait_n;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            wait_n = gaps_enabled ? $urandom_range(0, 3) : 0;
            if (sink_hold_cycles > 0) begin
                wait_n           = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (wait_n > 0) begin
                out_if.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // Every accepted speed command is compared with the oldest prediction.
    task automatic check_speed();
        t_speed_cmd want;
        if (pending_speeds.size() == 0) begin
            report_mismatch($sformatf("unexpected speed command lin=%0d ang=%0d",
                                      out_if.linear_mm_s, out_if.angular_mrad_s));
            return;
        end
        want = pending_speeds.pop_front();
        if (out_if.linear_mm_s !== want.lin)
            report_mismatch($sformatf("linear_mm_s %0d, expected %0d",
                                      out_if.linear_mm_s, want.lin));
        if (out_if.angular_mrad_s !== want.ang)
            report_mismatch($sformatf("angular_mrad_s %0d, expected %0d",
                                      out_if.angular_mrad_s, want.ang));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            check_speed();
    end

    // ------------------------------------------------------------------
    // Sequence of tests.
    // ------------------------------------------------------------------
    initial begin : main_sequence
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_if.valid     <= 1'b0;
        in_if.command   <= CMD_SAMPLE;
        in_if.angle_deg <= '0;
        in_if.range_mm  <= '0;
        in_if.at_home   <= 1'b0;
        clear_steering_state();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_default_scans();
        test_register_extremes();
        test_random_settings();
        test_back_to_back();
        test_output_stall();

        wait_for_drain();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/sms_pkg.sv
src/sms_if.sv
src/sms_cfg.sv
src/sms_front.sv
src/sms_fifo.sv
src/sms_back.sv
src/sector_minimum_wall_follow_steer.sv
tb/tb_top.sv
